/* rtl/websocket_frame_unmask_defines.svh */
// Assertion macros used by the checker file wsu_checker.sv.
`ifndef WEBSOCKET_FRAME_UNMASK_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define WSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("websocket_frame_unmask: check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define WSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("websocket_frame_unmask: check failed");

`endif

/* rtl/wsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wsu_pkg;

  localparam logic [6:0] LEN_MASK  = 7'h7f;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
  localparam logic [7:0] BYTE_MASK = 8'd255;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last_of_frame;
    logic       bad_length;
  } out_item_t;

  // Result of one parsed byte, handed to the output stage.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } parse_res_t;

endpackage

`default_nettype wire

/* rtl/wsu_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module wsu_parser
  import wsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire in_item_t   in_item,
  output parse_res_t      res
);

  typedef enum logic [2:0] {
    PH_DISCARD,
    PH_LENGTH,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [15:0] payload_left_r, payload_left_nxt;
  logic [1:0]  key_pos_r, key_pos_nxt;

  logic [6:0]  len_code;
  logic [7:0]  key_byte;
  logic [15:0] left_dec;

  assign len_code = in_item.in_byte[6:0] & LEN_MASK;
  assign key_byte = mask_key_r[{key_pos_r, 3'b000} +: 8];
  assign left_dec = (payload_left_r != 16'd0) ? (payload_left_r - 16'd1) : payload_left_r;

  always_comb begin
    phase_nxt        = phase_r;
    hdr_idx_nxt      = hdr_idx_r;
    mask_key_nxt     = mask_key_r;
    payload_left_nxt = payload_left_r;
    key_pos_nxt      = key_pos_r;
    res              = '0;

    if (in_item.frame_start) begin
      // A frame start always restarts, dropping any frame in progress.
      phase_nxt        = PH_LENGTH;
      hdr_idx_nxt      = 2'd0;
      mask_key_nxt     = 32'd0;
      payload_left_nxt = 16'd0;
      key_pos_nxt      = 2'd0;
    end else begin
      case (phase_r)
        PH_LENGTH: begin
          hdr_idx_nxt = 2'd0;
          if (len_code == LEN_EXT64) begin
            phase_nxt              = PH_DISCARD;
            res.valid              = 1'b1;
            res.item.last_of_frame = 1'b1;
            res.item.bad_length    = 1'b1;
          end else if (len_code == LEN_EXT16) begin
            payload_left_nxt = 16'd0;
            phase_nxt        = PH_EXTLEN;
          end else begin
            // Codes up to LEN_SHORT_MAX are the length itself.
            payload_left_nxt = {9'd0, len_code};
            phase_nxt        = PH_KEY;
          end
        end
        PH_EXTLEN: begin
          payload_left_nxt = {payload_left_r[7:0], in_item.in_byte};
          if (hdr_idx_r == 2'd1) begin
            hdr_idx_nxt = 2'd0;
            phase_nxt   = PH_KEY;
          end else begin
            hdr_idx_nxt = 2'd1;
          end
        end
        PH_KEY: begin
          mask_key_nxt[{hdr_idx_r, 3'b000} +: 8] = in_item.in_byte;
          if (hdr_idx_r == 2'd3) begin
            hdr_idx_nxt = 2'd0;
            key_pos_nxt = 2'd0;
            if (payload_left_r == 16'd0) begin
              phase_nxt              = PH_DISCARD;
              res.valid              = 1'b1;
              res.item.last_of_frame = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            hdr_idx_nxt = hdr_idx_r + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          key_pos_nxt            = key_pos_r + 2'd1;
          payload_left_nxt       = left_dec;
          res.valid              = 1'b1;
          res.item.data_byte     = in_item.in_byte ^ key_byte;
          res.item.has_data      = 1'b1;
          res.item.last_of_frame = (left_dec == 16'd0);
          if (left_dec == 16'd0) begin
            phase_nxt = PH_DISCARD;
          end
        end
        default: begin
          phase_nxt = PH_DISCARD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_DISCARD;
      hdr_idx_r      <= 2'd0;
      mask_key_r     <= 32'd0;
      payload_left_r <= 16'd0;
      key_pos_r      <= 2'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      hdr_idx_r      <= hdr_idx_nxt;
      mask_key_r     <= mask_key_nxt;
      payload_left_r <= payload_left_nxt;
      key_pos_r      <= key_pos_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/wsu_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module wsu_out_reg
  import wsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            step,
  input  wire parse_res_t res,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Hold the input only while a result waits and is not being taken.
  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = res.valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/websocket_frame_unmask.sv */
`timescale 1ns / 1ps
`default_nettype none
// Latency: a result appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle, set by the single output register; a byte is
// taken whenever the output register is empty or its transaction completes.
// Reset (synchronous, rst_n low): parser returns to discard-until-frame-start,
// header counters, key and length clear, and the output register empties.

module websocket_frame_unmask
  import wsu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  logic       step;
  parse_res_t res;

  wsu_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_item (in_data),
    .res     (res)
  );

  wsu_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .step      (step),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/wsu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_unmask_defines.svh"

module wsu_checker
  import wsu_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  `WSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `WSU_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `WSU_ASSERT_NOW(a_bad_len_form, out_valid && out_data.bad_length,
                  out_data.last_of_frame && !out_data.has_data)
  `WSU_ASSERT_NOW(a_empty_is_last, out_valid && !out_data.has_data,
                  out_data.last_of_frame && (out_data.data_byte == 8'd0))
  `WSU_ASSERT_NEXT(a_start_no_result, in_valid && !in_stall && in_data.frame_start,
                   !out_valid)

endmodule

bind websocket_frame_unmask wsu_checker u_wsu_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import wsu_pkg::*;

  typedef enum logic [2:0] {PS_SKIP, PS_LEN, PS_XLEN, PS_KEY, PS_DATA} parse_state_t;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NOTHING, EXP_TYPED} exp_mode_t;

  typedef struct {
    in_item_t  stim;
    exp_mode_t mode;
    out_item_t want;
  } dir_row_t;

  localparam out_item_t BAD_LEN     = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam out_item_t EMPTY_FRAME = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam out_item_t NO_RESULT   = '{8'h00, 1'b0, 1'b0, 1'b0};
  localparam int        N_DIR       = 27;
  localparam int        N_RANDOM    = 1050;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  websocket_frame_unmask i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Predictor state
  parse_state_t parse_st  = PS_SKIP;
  logic [1:0]   hdr_cnt   = 2'd0;
  logic [31:0]  key_word  = 32'd0;
  logic [15:0]  bytes_left = 16'd0;
  logic [1:0]   key_idx   = 2'd0;

  out_item_t unmasked_q [$];
  int        mismatch_cnt = 0;
  int        n_items      = 0;
  bit        idle_on      = 1'b1;
  int        stall_left   = 0;

  dir_row_t dir_rows [0:N_DIR-1] = '{
    // byte before any frame start
    '{'{8'hAA, 1'b0}, EXP_NOTHING, NO_RESULT},
    // code 127 with mask bit set, then a discarded byte
    '{'{8'h81, 1'b1}, EXP_NOTHING, NO_RESULT},
    '{'{8'hFF, 1'b0}, EXP_TYPED,   BAD_LEN},
    '{'{8'h55, 1'b0}, EXP_NOTHING, NO_RESULT},
    // zero-length frame
    '{'{8'h82, 1'b1}, EXP_NOTHING, NO_RESULT},
    '{'{8'h80, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h00, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'hFF, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h12, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h34, 1'b0}, EXP_TYPED,   EMPTY_FRAME},
    // short length 125, cut short by a new frame start
    '{'{8'h01, 1'b1}, EXP_NOTHING, NO_RESULT},
    '{'{8'h7D, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'hAA, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h55, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'hFF, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h00, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h00, 1'b0}, EXP_PREDICT, NO_RESULT},
    '{'{8'hFF, 1'b0}, EXP_PREDICT, NO_RESULT},
    // 16-bit length of one
    '{'{8'hFF, 1'b1}, EXP_NOTHING, NO_RESULT},
    '{'{8'h7E, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h00, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h01, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h0F, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'hF0, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'h3C, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'hC3, 1'b0}, EXP_NOTHING, NO_RESULT},
    '{'{8'hFF, 1'b0}, EXP_PREDICT, NO_RESULT}
  };

  function automatic bit unmask_predict(input in_item_t it, output out_item_t res);
    logic [6:0] code;
    res  = '0;
    code = it.in_byte[6:0];
    if (it.frame_start) begin
      parse_st   = PS_LEN;
      hdr_cnt    = 2'd0;
      key_word   = 32'd0;
      bytes_left = 16'd0;
      key_idx    = 2'd0;
      return 1'b0;
    end
    case (parse_st)
      PS_LEN: begin
        hdr_cnt = 2'd0;
        if (code == LEN_EXT64) begin
          parse_st          = PS_SKIP;
          res.last_of_frame = 1'b1;
          res.bad_length    = 1'b1;
          return 1'b1;
        end
        if (code == LEN_EXT16) begin
          bytes_left = 16'd0;
          parse_st   = PS_XLEN;
        end else begin
          bytes_left = {9'd0, code};
          parse_st   = PS_KEY;
        end
        return 1'b0;
      end
      PS_XLEN: begin
        bytes_left = {bytes_left[7:0], it.in_byte};
        if (hdr_cnt == 2'd1) begin
          hdr_cnt  = 2'd0;
          parse_st = PS_KEY;
        end else begin
          hdr_cnt = 2'd1;
        end
        return 1'b0;
      end
      PS_KEY: begin
        key_word[8*hdr_cnt +: 8] = it.in_byte;
        if (hdr_cnt == 2'd3) begin
          hdr_cnt = 2'd0;
          key_idx = 2'd0;
          if (bytes_left == 16'd0) begin
            parse_st          = PS_SKIP;
            res.last_of_frame = 1'b1;
            return 1'b1;
          end
          parse_st = PS_DATA;
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
        return 1'b0;
      end
      PS_DATA: begin
        res.data_byte = it.in_byte ^ key_word[8*key_idx +: 8];
        res.has_data  = 1'b1;
        key_idx       = key_idx + 2'd1;
        if (bytes_left != 16'd0) bytes_left = bytes_left - 16'd1;
        res.last_of_frame = (bytes_left == 16'd0);
        if (res.last_of_frame) parse_st = PS_SKIP;
        return 1'b1;
      end
      default: begin
        parse_st = PS_SKIP;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input in_item_t it, input exp_mode_t mode, input out_item_t want);
    out_item_t res;
    bit        got;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = unmask_predict(it, res);
    case (mode)
      EXP_PREDICT: if (got) unmasked_q.insert(unmasked_q.size(), res);
      EXP_TYPED:   unmasked_q.insert(unmasked_q.size(), want);
      default:     ;
    endcase
  endtask

  // Noise bytes are ones the block just drops; they do not count as items.
  task automatic put(input logic [7:0] b, input logic s, input bit noise);
    in_item_t it;
    it.in_byte     = b;
    it.frame_start = s;
    send_byte(it, EXP_PREDICT, NO_RESULT);
    if (!noise) n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (unmasked_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame();
    int          kind;
    int          len;
    int          n;
    int          cut;
    logic        mb;
    logic [6:0]  code;
    logic [15:0] xlen;
    // cut >= 0 may abort the header early; the next frame start drops the frame
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : -1;
    mb   = 1'($urandom_range(0, 1));
    kind = $urandom_range(0, 99);
    put(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    if (kind < 8) begin
      put({mb, LEN_EXT64}, 1'b0, 1'b0);
      repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    if (kind < 55) begin
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 8);
      code = len[6:0];
      put({mb, code}, 1'b0, 1'b0);
    end else begin
      xlen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 48));
      put({mb, LEN_EXT16}, 1'b0, 1'b0);
      if (cut == 0) return;
      put(xlen[15:8], 1'b0, 1'b0);
      if (cut == 1) return;
      put(xlen[7:0], 1'b0, 1'b0);
      len = xlen;
    end
    for (int k = 0; k < 4; k++) begin
      if (cut == k + 2) return;
      put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    // Keep long frames short; the next frame start cuts them off.
    n = (len > 64) ? $urandom_range(0, 64) : len;
    for (int k = 0; k < n; k++) put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    if (n == len && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (unmasked_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: expected no result, actual %h", $time, out_data);
      end else begin
        want = unmasked_q.pop_front();
        if (out_data.data_byte !== want.data_byte) begin
          mismatch_cnt++;
          $display("%0t: data_byte expected %h actual %h",
                   $time, want.data_byte, out_data.data_byte);
        end
        if (out_data.has_data !== want.has_data) begin
          mismatch_cnt++;
          $display("%0t: has_data expected %b actual %b",
                   $time, want.has_data, out_data.has_data);
        end
        if (out_data.last_of_frame !== want.last_of_frame) begin
          mismatch_cnt++;
          $display("%0t: last_of_frame expected %b actual %b",
                   $time, want.last_of_frame, out_data.last_of_frame);
        end
        if (out_data.bad_length !== want.bad_length) begin
          mismatch_cnt++;
          $display("%0t: bad_length expected %b actual %b",
                   $time, want.bad_length, out_data.bad_length);
        end
      end
    end
    // hold the result side in bursts
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 16) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    bit drained;
    drained = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < N_DIR; i++)
      send_byte(dir_rows[i].stim, dir_rows[i].mode, dir_rows[i].want);
    drain();
    n_items = 0;
    while (n_items < N_RANDOM) begin
      if (!drained && n_items >= N_RANDOM / 2) begin
        drain();
        drained = 1'b1;
      end
      if (n_items >= N_RANDOM - 150) idle_on = 1'b0;
      send_frame();
    end
    drain();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0 && unmasked_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
